// ----- design/mtrs_pkg.sv -----
// Package for the Modbus TCP relay server core: protocol constants,
// function codes and the sequencer state type. No dependencies.
`default_nettype none
package mtrs_pkg;
    localparam int RelayCountDef = 4;
    localparam int FrameBytesDef = 64;
    localparam int HoldingRegCount = 8;
    localparam int LenLimit = 250;
    localparam int HdrBytes = 6;
    localparam int FetchBytes = 15;

    localparam logic [7:0] FcReadCoils = 8'h01;
    localparam logic [7:0] FcReadRegs = 8'h03;
    localparam logic [7:0] FcWriteCoil = 8'h05;
    localparam logic [7:0] FcWriteReg = 8'h06;
    localparam logic [7:0] FcWriteCoils = 8'h0F;
    localparam logic [7:0] ExcFlag = 8'h80;
    localparam logic [7:0] ExcFunc = 8'h01;
    localparam logic [7:0] ExcAddr = 8'h02;
    localparam logic [15:0] CoilOn = 16'hFF00;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_LAST  = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_SEND  = 5'b10000
    } t_state;
endpackage
`default_nettype wire

// ----- design/modbus_tcp_relay_slave_core.sv -----
// Modbus TCP server core for a small relay bank: frame store, request decode
// and response generation. Depends on mtrs_pkg.
// After the byte that completes a frame the core runs a fetch pass over the frame
// store (one read per cycle), an extra read state and an execute state, then sends
// response bytes one per cycle while i_m_axis_tready is high. Request bytes are
// taken one per cycle only while the core is idle (no fetch, execute or send).
// Reset (synchronous, active low) clears byte count, drop flag and relays.
`default_nettype none
module modbus_tcp_relay_slave_core #(
    parameter int RELAY_COUNT = mtrs_pkg::RelayCountDef,
    parameter int FRAME_BYTES = mtrs_pkg::FrameBytesDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // rx_byte[7:0], wifi_connected[8], mqtt_connected[9], rssi_magnitude[17:10],
    // uptime_seconds[49:18], zero fill [55:50]
    input  wire logic [55:0] i_s_axis_tdata,
    // frame_start[0]
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tx_byte[7:0], relay_bits[11:8], zero fill [15:12]
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);
    import mtrs_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LenMax = (LenLimit < FRAME_BYTES - HdrBytes) ? LenLimit
                                                               : FRAME_BYTES - HdrBytes;

    logic [7:0]             r_mem [FRAME_BYTES];
    logic [7:0]             r_rdata;
    t_state                 r_state;
    logic [CW-1:0]          r_cnt;
    logic                   r_drop;
    logic [7:0]             r_len_hi;
    logic [15:0]            r_len;
    logic [3:0]             r_fidx;
    logic [3:0]             r_ridx;
    logic                   r_rvld;
    logic [7:0]             r_fb [FetchBytes];
    logic                   r_wifi;
    logic                   r_mqtt;
    logic [7:0]             r_rssi;
    logic [31:0]            r_up;
    logic [RELAY_COUNT-1:0] r_relay;
    logic [4:0]             r_idx;

    logic          in_acc;
    logic          fs;
    logic [CW-1:0] cnt_eff;
    logic          drop_eff;
    logic [CW-1:0] c1;
    logic [15:0]   len_now;
    logic          len_bad;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign fs       = i_s_axis_tuser[0];
    assign cnt_eff  = fs ? '0 : r_cnt;
    assign drop_eff = fs ? 1'b0 : r_drop;
    assign c1       = cnt_eff + CW'(1);
    assign len_now  = (cnt_eff == CW'(5)) ? {r_len_hi, i_s_axis_tdata[7:0]} : r_len;
    assign len_bad  = (len_now == 16'd0) || (32'(len_now) > LenMax);

    // Request decode from the fetched header bytes.
    logic [7:0]  fc;
    logic [15:0] start;
    logic [15:0] qty;
    logic [16:0] span;
    logic        coil_ok;
    logic        reg_ok;
    logic        one_ok;
    logic        exc;
    logic [7:0]  exc_code;
    logic [1:0]  nb;
    logic [4:0]  plen;
    logic [4:0]  total;
    logic [15:0] coil_vec;
    logic [15:0] wdata;

    assign fc      = r_fb[7];
    assign start   = {r_fb[8], r_fb[9]};
    assign qty     = {r_fb[10], r_fb[11]};
    assign wdata   = {r_fb[14], r_fb[13]};
    assign span    = 17'(start) + 17'(qty);
    assign one_ok  = 32'(start) < RELAY_COUNT;
    assign coil_ok = one_ok && (32'(span) <= RELAY_COUNT);
    assign reg_ok  = 32'(span) <= HoldingRegCount;

    always_comb begin
        exc      = 1'b0;
        exc_code = ExcAddr;
        unique case (fc)
            FcReadCoils:  exc = !coil_ok;
            FcReadRegs:   exc = !reg_ok;
            FcWriteCoil:  exc = !one_ok;
            FcWriteReg:   exc = !one_ok;
            FcWriteCoils: exc = !coil_ok;
            default: begin
                exc      = 1'b1;
                exc_code = ExcFunc;
            end
        endcase
    end

    always_comb begin
        nb = (qty > 16'd8) ? 2'd2 : 2'd1;
        if (exc) begin
            plen = 5'd2;
        end else begin
            unique case (fc)
                FcReadCoils: plen = 5'd2 + 5'(nb);
                FcReadRegs:  plen = 5'd2 + {qty[3:0], 1'b0};
                default:     plen = 5'd5;
            endcase
        end
        total = plen + 5'd7;
    end

    always_comb begin
        for (int b = 0; b < 16; b++) begin
            coil_vec[b] = 1'b0;
            for (int r = 0; r < RELAY_COUNT; r++) begin
                if ((32'(b) < 32'(qty)) && (32'(start) + b == r))
                    coil_vec[b] = r_relay[r];
            end
        end
    end

    // Response byte at the current send index.
    logic [4:0]  m;
    logic [2:0]  hreg;
    logic [15:0] hval;
    logic [7:0]  tx_byte;
    logic [3:0]  relay_out;

    assign m    = r_idx - 5'd7;
    assign hreg = start[2:0] + 3'(4'(m - 5'd2) >> 1);

    always_comb begin
        hval = 16'd0;
        unique case (hreg)
            3'd4: hval = {14'd0, r_mqtt, r_wifi};
            3'd5: hval = {8'd0, r_rssi};
            3'd6: hval = r_up[15:0];
            3'd7: hval = r_up[31:16];
            default: begin
                for (int r = 0; r < RELAY_COUNT; r++)
                    if (r == 32'(hreg)) hval = {15'd0, r_relay[r]};
            end
        endcase
    end

    always_comb begin
        tx_byte = 8'd0;
        priority if (r_idx < 5'd7) begin
            unique case (r_idx)
                5'd0:    tx_byte = r_fb[0];
                5'd1:    tx_byte = r_fb[1];
                5'd5:    tx_byte = 8'(plen) + 8'd1;
                5'd6:    tx_byte = r_fb[6];
                default: tx_byte = 8'd0;
            endcase
        end else if (exc) begin
            tx_byte = (m == 5'd0) ? (fc | ExcFlag) : exc_code;
        end else if (fc == FcReadCoils) begin
            priority if (m == 5'd0) tx_byte = FcReadCoils;
            else if (m == 5'd1) tx_byte = 8'(nb);
            else if (m == 5'd2) tx_byte = coil_vec[7:0];
            else tx_byte = coil_vec[15:8];
        end else if (fc == FcReadRegs) begin
            priority if (m == 5'd0) tx_byte = FcReadRegs;
            else if (m == 5'd1) tx_byte = {qty[6:0], 1'b0};
            else if (m[0]) tx_byte = hval[7:0];
            else tx_byte = hval[15:8];
        end else begin
            tx_byte = (m < 5'd5) ? r_fb[4'd7 + m[3:0]] : 8'd0;
        end
    end

    always_comb begin
        relay_out = 4'd0;
        for (int r = 0; r < 4; r++)
            if (r < RELAY_COUNT) relay_out[r] = r_relay[r];
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_SEND);
    assign o_m_axis_tdata  = {4'd0, relay_out, tx_byte};
    assign o_m_axis_tlast  = (r_idx == total - 5'd1);

    // Frame store: written in request order, read back during the fetch pass.
    always_ff @(posedge i_clk) begin
        if (in_acc && !drop_eff && (32'(cnt_eff) < FRAME_BYTES))
            r_mem[cnt_eff[AW-1:0]] <= i_s_axis_tdata[7:0];
        r_rdata <= r_mem[AW'(r_fidx)];
    end

    always_ff @(posedge i_clk) begin
        if (r_rvld)
            r_fb[r_ridx] <= (CW'(r_ridx) < r_cnt) ? r_rdata : 8'd0;
        if (in_acc) begin
            if (cnt_eff == CW'(4)) r_len_hi <= i_s_axis_tdata[7:0];
            if (cnt_eff == CW'(5)) r_len <= len_now;
            r_wifi <= i_s_axis_tdata[8];
            r_mqtt <= i_s_axis_tdata[9];
            r_rssi <= i_s_axis_tdata[17:10];
            r_up   <= i_s_axis_tdata[49:18];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_relay <= '0;
            r_fidx  <= 4'd0;
            r_ridx  <= 4'd0;
            r_rvld  <= 1'b0;
            r_idx   <= 5'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_rvld <= 1'b0;
                    if (in_acc) begin
                        priority if (drop_eff || (32'(cnt_eff) >= FRAME_BYTES)) begin
                            r_cnt  <= cnt_eff;
                            r_drop <= 1'b1;
                        end else begin
                            r_cnt  <= c1;
                            r_drop <= (c1 >= CW'(HdrBytes)) && len_bad;
                            if ((c1 >= CW'(HdrBytes)) && !len_bad
                                && (32'(c1) >= 32'(len_now) + HdrBytes)) begin
                                r_fidx  <= 4'd0;
                                r_state <= ST_FETCH;
                            end
                        end
                    end
                end
                ST_FETCH: begin
                    r_rvld <= 1'b1;
                    r_ridx <= r_fidx;
                    r_fidx <= r_fidx + 4'd1;
                    if (r_fidx == 4'(FetchBytes - 1)) r_state <= ST_LAST;
                end
                ST_LAST: begin
                    r_rvld  <= 1'b0;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_cnt <= '0;
                    r_idx <= 5'd0;
                    if ({r_fb[2], r_fb[3]} != 16'd0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_SEND;
                        if (!exc) begin
                            for (int r = 0; r < RELAY_COUNT; r++) begin
                                if (fc == FcWriteCoil && start == 16'(r))
                                    r_relay[r] <= (qty == CoilOn);
                                if (fc == FcWriteReg && start == 16'(r))
                                    r_relay[r] <= (qty != 16'd0);
                                if (fc == FcWriteCoils && (32'(start) <= r)
                                    && (r < 32'(span)))
                                    r_relay[r] <= wdata[4'(r - 32'(start))];
                            end
                        end
                    end
                end
                ST_SEND: begin
                    if (i_m_axis_tready) begin
                        r_idx <= r_idx + 5'd1;
                        if (o_m_axis_tlast) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output active together");

    a_relay_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(r_state == ST_EXEC)) |-> $stable(r_relay))
        else $error("relays changed outside execute");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_idx < total))
        else $error("send index past response end");

    a_fetch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !r_rvld)
        else $error("execute before fetch finished");
endmodule
`default_nettype wire
